>>> design/sbgr_pkg.sv
`timescale 1ns / 1ps

package sbgr_pkg;

    typedef enum logic [1:0] {
        OP_LOAD_GLYPH  = 2'd0,
        OP_LOAD_WIDTH  = 2'd1,
        OP_LOAD_OFFSET = 2'd2,
        OP_DRAW        = 2'd3
    } op_t;

    // configuration register indexes
    localparam logic [2:0] CFG_FIRST_CHAR   = 3'd0;
    localparam logic [2:0] CFG_GLYPH_COUNT  = 3'd1;
    localparam logic [2:0] CFG_MAX_WIDTH    = 3'd2;
    localparam logic [2:0] CFG_GLYPH_HEIGHT = 3'd3;
    localparam logic [2:0] CFG_USE_WIDTH    = 3'd4;
    localparam logic [2:0] CFG_USE_OFFSET   = 3'd5;

    localparam logic [7:0] FIRST_CHAR_RST   = 8'd32;
    localparam logic [8:0] GLYPH_COUNT_RST  = 9'd96;
    localparam logic [4:0] MAX_WIDTH_RST    = 5'd8;
    localparam logic [4:0] GLYPH_HEIGHT_RST = 5'd16;

    localparam logic [4:0]  MAX_GLYPH_WIDTH = 5'd16;
    localparam logic [15:0] GLYPH_MSB       = 16'h8000;
    localparam logic [15:0] GLYPH_ALL_ONES  = 16'hFFFF;

    // one character-table entry: width and start word share a row
    typedef struct packed {
        logic [4:0]  width;
        logic [11:0] offset;
    } char_entry_t;

endpackage

>>> design/scaled_bitmap_glyph_row_renderer.sv
`timescale 1ns / 1ps

// Bitmap glyph row renderer.
// Input channel s_*: one beat is a load (glyph word, width entry or offset
// entry) or a draw of one glyph row. Result channel m_*: one beat per set dot
// of the drawn row, left to right, last_block high on the final one; a row
// with no set dots, off-font character, bad row or zero scale gives no beat.
// Configuration channel cfg_*: always ready, one register per beat.
// A glyph word load is written while idle; a width or offset load passes
// through ST_CT_WRITE (read-modify-write of the shared character-table row).
// A draw reaches its first dot through character-table read, glyph-word
// read and word latch, then scans one glyph column per cycle, holding on a
// set dot while the output slot is busy, up to the last set dot of at most
// 16 columns; the first block is registered from ST_EMIT.
// The result sits in an output register; while the receiver stalls the
// column scan holds at the next set dot, and the next input beat is taken
// as soon as the scan ends even if the last block still waits.
// Reset restores the configuration defaults and empties the output
// register; glyph and character memories are not cleared and hold
// undefined data until loaded.
module scaled_bitmap_glyph_row_renderer
    import sbgr_pkg::*;
#(
    parameter int GLYPH_STORE_WORDS = 4096,
    parameter int CHAR_TABLE_DEPTH  = 256
) (
    input  logic               aclk,
    input  logic               aresetn,

    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [15:0]        cfg_wdata,

    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_operation,
    input  logic [11:0]        s_load_index,
    input  logic [15:0]        s_load_value,
    input  logic [7:0]         s_char_code,
    input  logic [3:0]         s_glyph_row,
    input  logic signed [10:0] s_origin_x,
    input  logic signed [10:0] s_origin_y,
    input  logic [15:0]        s_ink_color,
    input  logic [4:0]         s_scale_factor,

    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [11:0] m_block_x,
    output logic signed [11:0] m_block_y,
    output logic [4:0]         m_block_size,
    output logic [15:0]        m_block_color,
    output logic               m_last_block
);

    localparam int AW = $clog2(GLYPH_STORE_WORDS);
    localparam int CW = $clog2(CHAR_TABLE_DEPTH);
    localparam int SW = 13;   // start word plus row, before wrapping

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CT_WRITE,
        ST_LOOKUP,
        ST_FETCH,
        ST_EMIT
    } state_t;

    state_t state_reg;

    // configuration
    logic [7:0] first_char_reg;
    logic [8:0] glyph_count_reg;
    logic [4:0] max_width_reg;
    logic [4:0] glyph_height_reg;
    logic       use_width_reg;
    logic       use_offset_reg;

    // captured item
    logic [1:0]         op_reg;
    logic [15:0]        value_reg;
    logic [CW-1:0]      ct_addr_reg;
    logic [3:0]         row_reg;
    logic [4:0]         scale_reg;
    logic [15:0]        color_reg;
    logic signed [10:0] ox_reg;
    logic signed [10:0] oy_reg;
    logic [SW-1:0]      prod_idx_reg;
    logic [8:0]         prod_row_reg;

    // scan state
    logic [4:0]  width_reg;
    logic [15:0] word_reg;
    logic [11:0] x_acc_reg;
    logic [11:0] y_reg;

    // output register
    logic        m_valid_reg;
    logic [11:0] m_block_x_reg;
    logic [11:0] m_block_y_reg;
    logic [4:0]  m_block_size_reg;
    logic [15:0] m_block_color_reg;
    logic        m_last_block_reg;

    // memories
    logic [15:0]  glyph_mem [GLYPH_STORE_WORDS];
    char_entry_t  char_mem  [CHAR_TABLE_DEPTH];
    logic [15:0]  glyph_rdata;
    char_entry_t  char_rdata;
    logic [AW-1:0] glyph_raddr;
    logic [CW-1:0] char_raddr;
    logic          glyph_we;
    logic          char_we;
    char_entry_t   char_wdata;

    logic        s_fire;
    logic [8:0]  char_diff;
    logic [7:0]  char_idx;
    logic        draw_ok;
    logic        load_ct_ok;
    logic [4:0]  width_sel;
    logic [SW-1:0] start_word;
    logic [SW-1:0] word_addr;
    logic [15:0] width_mask;
    logic [15:0] word_masked;
    logic        slot_free;
    logic        emit_step;
    logic        emit_load;
    logic        emit_done;

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == ST_IDLE);
    assign s_fire    = s_valid && s_ready;

    // draw qualification, all compares side by side
    assign char_diff = {1'b0, s_char_code} - {1'b0, first_char_reg};
    assign char_idx  = char_diff[7:0];
    assign draw_ok   = !char_diff[8]
                    && ({1'b0, char_idx} < glyph_count_reg)
                    && ({1'b0, s_glyph_row} < glyph_height_reg)
                    && (s_scale_factor != 5'd0)
                    && !((use_width_reg || use_offset_reg)
                         && (32'(char_idx) >= CHAR_TABLE_DEPTH));
    assign load_ct_ok = (32'(s_load_index) < CHAR_TABLE_DEPTH);

    assign char_raddr = (op_t'(s_operation) == OP_DRAW) ? char_idx[CW-1:0]
                                                        : s_load_index[CW-1:0];
    assign glyph_we   = s_fire && (op_t'(s_operation) == OP_LOAD_GLYPH)
                     && (32'(s_load_index) < GLYPH_STORE_WORDS);
    assign char_we    = (state_reg == ST_CT_WRITE);

    always_comb begin
        char_wdata = char_rdata;
        if (op_t'(op_reg) == OP_LOAD_WIDTH) begin
            char_wdata.width = value_reg[4:0];
        end else begin
            char_wdata.offset = value_reg[11:0];
        end
    end

    // width select and clamp
    always_comb begin
        width_sel = use_width_reg ? char_rdata.width : max_width_reg;
        if (width_sel > MAX_GLYPH_WIDTH) begin
            width_sel = MAX_GLYPH_WIDTH;
        end
    end

    // start word plus row, wrapped to the store by folding multiples of its size
    always_comb begin
        logic [SW-1:0] r;
        start_word = use_offset_reg ? SW'(char_rdata.offset) : prod_idx_reg;
        r = start_word + SW'(row_reg);
        for (int k = 4; k >= 0; k--) begin
            if (32'(r) >= (32'(GLYPH_STORE_WORDS) << k)) begin
                r = r - SW'(32'(GLYPH_STORE_WORDS) << k);
            end
        end
        word_addr = r;
    end
    assign glyph_raddr = AW'(word_addr);

    assign width_mask  = ~(GLYPH_ALL_ONES >> width_reg);
    assign word_masked = glyph_rdata & width_mask;

    // column scan: a clear dot always advances, a set dot needs the output slot
    assign slot_free = !m_valid_reg || m_ready;
    assign emit_step = (state_reg == ST_EMIT)
                    && (((word_reg & GLYPH_MSB) == 16'd0) || slot_free);
    assign emit_load = emit_step && ((word_reg & GLYPH_MSB) != 16'd0);
    assign emit_done = (word_reg[14:0] == 15'd0);

    always_ff @(posedge aclk) begin
        if (glyph_we) begin
            glyph_mem[AW'(s_load_index)] <= s_load_value;
        end
        glyph_rdata <= glyph_mem[glyph_raddr];
    end

    always_ff @(posedge aclk) begin
        if (char_we) begin
            char_mem[ct_addr_reg] <= char_wdata;
        end
        char_rdata <= char_mem[char_raddr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            m_valid_reg      <= 1'b0;
            first_char_reg   <= FIRST_CHAR_RST;
            glyph_count_reg  <= GLYPH_COUNT_RST;
            max_width_reg    <= MAX_WIDTH_RST;
            glyph_height_reg <= GLYPH_HEIGHT_RST;
            use_width_reg    <= 1'b0;
            use_offset_reg   <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_FIRST_CHAR:   first_char_reg   <= cfg_wdata[7:0];
                    CFG_GLYPH_COUNT:  glyph_count_reg  <= cfg_wdata[8:0];
                    CFG_MAX_WIDTH:    max_width_reg    <= cfg_wdata[4:0];
                    CFG_GLYPH_HEIGHT: glyph_height_reg <= cfg_wdata[4:0];
                    CFG_USE_WIDTH:    use_width_reg    <= cfg_wdata[0];
                    CFG_USE_OFFSET:   use_offset_reg   <= cfg_wdata[0];
                    default: ;
                endcase
            end

            if (m_valid_reg && m_ready && !emit_load) begin
                m_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE: begin
                    if (s_fire) begin
                        op_reg       <= s_operation;
                        value_reg    <= s_load_value;
                        ct_addr_reg  <= s_load_index[CW-1:0];
                        row_reg      <= s_glyph_row;
                        scale_reg    <= s_scale_factor;
                        color_reg    <= s_ink_color;
                        ox_reg       <= s_origin_x;
                        oy_reg       <= s_origin_y;
                        prod_idx_reg <= SW'(char_idx) * SW'(glyph_height_reg);
                        prod_row_reg <= 9'(s_glyph_row) * 9'(s_scale_factor);
                        case (op_t'(s_operation))
                            OP_LOAD_WIDTH, OP_LOAD_OFFSET: begin
                                if (load_ct_ok) begin
                                    state_reg <= ST_CT_WRITE;
                                end
                            end
                            OP_DRAW: begin
                                if (draw_ok) begin
                                    state_reg <= ST_LOOKUP;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                ST_CT_WRITE: begin
                    state_reg <= ST_IDLE;
                end
                ST_LOOKUP: begin
                    width_reg <= width_sel;
                    y_reg     <= 12'(oy_reg) + 12'(prod_row_reg);
                    state_reg <= ST_FETCH;
                end
                ST_FETCH: begin
                    word_reg  <= word_masked;
                    x_acc_reg <= 12'(ox_reg);
                    state_reg <= (word_masked == 16'd0) ? ST_IDLE : ST_EMIT;
                end
                ST_EMIT: begin
                    if (emit_step) begin
                        word_reg  <= word_reg << 1;
                        x_acc_reg <= x_acc_reg + 12'(scale_reg);
                        if (emit_done) begin
                            state_reg <= ST_IDLE;
                        end
                    end
                    if (emit_load) begin
                        m_valid_reg       <= 1'b1;
                        m_block_x_reg     <= x_acc_reg;
                        m_block_y_reg     <= y_reg;
                        m_block_size_reg  <= scale_reg;
                        m_block_color_reg <= color_reg;
                        m_last_block_reg  <= emit_done;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_block_x     = m_block_x_reg;
    assign m_block_y     = m_block_y_reg;
    assign m_block_size  = m_block_size_reg;
    assign m_block_color = m_block_color_reg;
    assign m_last_block  = m_last_block_reg;

    // scan never runs on an empty word
    a_emit_word_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_EMIT |-> word_reg != 16'd0)
        else $error("column scan entered with no dots left");

    // a pending beat is never overwritten
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        emit_load |-> slot_free)
        else $error("output register overwritten while stalled");

    // last block ends the scan
    a_last_ends_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        emit_load && emit_done |=> state_reg == ST_IDLE && m_valid_reg && m_last_block_reg)
        else $error("scan continued past last block");

    // clamped width reaches the mask
    a_width_clamped: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_FETCH |-> width_reg <= MAX_GLYPH_WIDTH)
        else $error("glyph width above limit");

endmodule

>>> tb/sv/scaled_bitmap_glyph_row_renderer_tb.sv
`timescale 1ns / 1ps

module scaled_bitmap_glyph_row_renderer_tb
    import sbgr_pkg::*;
();

    localparam int GLYPH_WORDS  = 4096;
    localparam int CHAR_DEPTH   = 256;
    localparam int DRAIN_CYCLES = 24;
    localparam int LIMIT_CYCLES = 600000;

    typedef struct {
        op_t               op;
        logic [11:0]       load_index;
        logic [15:0]       load_value;
        logic [7:0]        char_code;
        logic [3:0]        glyph_row;
        logic signed [10:0] origin_x;
        logic signed [10:0] origin_y;
        logic [15:0]       ink_color;
        logic [4:0]        scale;
    } render_req_t;

    typedef struct {
        logic signed [11:0] x;
        logic signed [11:0] y;
        logic [4:0]         size;
        logic [15:0]        color;
        logic               last;
    } dot_block_t;

    typedef enum {READY_ALWAYS, READY_MOSTLY, READY_SELDOM, READY_PERIODIC} ready_style_t;

    logic               aclk;
    logic               aresetn;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [2:0]         cfg_index;
    logic [15:0]        cfg_wdata;
    logic               s_valid;
    logic               s_ready;
    logic [1:0]         s_operation;
    logic [11:0]        s_load_index;
    logic [15:0]        s_load_value;
    logic [7:0]         s_char_code;
    logic [3:0]         s_glyph_row;
    logic signed [10:0] s_origin_x;
    logic signed [10:0] s_origin_y;
    logic [15:0]        s_ink_color;
    logic [4:0]         s_scale_factor;
    logic               m_valid;
    logic               m_ready;
    logic signed [11:0] m_block_x;
    logic signed [11:0] m_block_y;
    logic [4:0]         m_block_size;
    logic [15:0]        m_block_color;
    logic               m_last_block;

    // font held by the predictor
    logic [7:0]  font_first;
    logic [8:0]  font_count;
    logic [4:0]  font_max_width;
    logic [4:0]  font_height;
    logic        font_use_width;
    logic        font_use_offset;
    logic [15:0] glyph_mem [GLYPH_WORDS];
    bit          glyph_loaded [GLYPH_WORDS];
    logic [4:0]  width_mem [CHAR_DEPTH];
    bit          width_loaded [CHAR_DEPTH];
    logic [11:0] offset_mem [CHAR_DEPTH];
    bit          offset_loaded [CHAR_DEPTH];

    dot_block_t   expected_blocks[$];
    dot_block_t   want_block;
    int           error_count = 0;
    int           cycle_count = 0;
    int           burst_left = 0;
    ready_style_t ready_style = READY_ALWAYS;

    scaled_bitmap_glyph_row_renderer uut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_operation    (s_operation),
        .s_load_index   (s_load_index),
        .s_load_value   (s_load_value),
        .s_char_code    (s_char_code),
        .s_glyph_row    (s_glyph_row),
        .s_origin_x     (s_origin_x),
        .s_origin_y     (s_origin_y),
        .s_ink_color    (s_ink_color),
        .s_scale_factor (s_scale_factor),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_block_x      (m_block_x),
        .m_block_y      (m_block_y),
        .m_block_size   (m_block_size),
        .m_block_color  (m_block_color),
        .m_last_block   (m_last_block)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // ---------------------------------------------------------------- predictor

    function automatic bit glyph_in_font(input logic [7:0] ch, input logic [3:0] row,
                                         input logic [4:0] scale, output int idx);
        idx = int'(ch) - int'(font_first);
        if (idx < 0 || idx >= int'(font_count))
            return 0;
        if (row >= font_height || scale == 0)
            return 0;
        if ((font_use_width || font_use_offset) && idx >= CHAR_DEPTH)
            return 0;
        return 1;
    endfunction

    function automatic int glyph_addr(input int idx, input logic [3:0] row);
        int start;
        start = font_use_offset ? int'(offset_mem[idx]) : idx * int'(font_height);
        return (start + int'(row)) % GLYPH_WORDS;
    endfunction

    function automatic void apply_font_item(input render_req_t r);
        int          idx;
        int          wid;
        int          col;
        int          bx;
        int          by;
        logic [15:0] word;
        dot_block_t  blk;
        dot_block_t  row_blocks[$];
        case (r.op)
            OP_LOAD_GLYPH: begin
                glyph_mem[r.load_index] = r.load_value;
                glyph_loaded[r.load_index] = 1'b1;
            end
            OP_LOAD_WIDTH: begin
                if (r.load_index < CHAR_DEPTH) begin
                    width_mem[r.load_index] = r.load_value[4:0];
                    width_loaded[r.load_index] = 1'b1;
                end
            end
            OP_LOAD_OFFSET: begin
                if (r.load_index < CHAR_DEPTH) begin
                    offset_mem[r.load_index] = r.load_value[11:0];
                    offset_loaded[r.load_index] = 1'b1;
                end
            end
            OP_DRAW: begin
                if (glyph_in_font(r.char_code, r.glyph_row, r.scale, idx)) begin
                    wid = font_use_width ? int'(width_mem[idx]) : int'(font_max_width);
                    if (wid > int'(MAX_GLYPH_WIDTH))
                        wid = int'(MAX_GLYPH_WIDTH);
                    word = glyph_mem[glyph_addr(idx, r.glyph_row)];
                    for (col = 0; col < wid; col++) begin
                        if (word[15 - col]) begin
                            bx = int'(r.origin_x) + int'(r.scale) * col;
                            by = int'(r.origin_y) + int'(r.scale) * int'(r.glyph_row);
                            blk.x     = bx[11:0];
                            blk.y     = by[11:0];
                            blk.size  = r.scale;
                            blk.color = r.ink_color;
                            blk.last  = 1'b0;
                            row_blocks.push_back(blk);
                        end
                    end
                    if (row_blocks.size() > 0)
                        row_blocks[row_blocks.size() - 1].last = 1'b1;
                    foreach (row_blocks[i])
                        expected_blocks.push_back(row_blocks[i]);
                end
            end
            default: ;
        endcase
    endfunction

    function automatic void apply_config(input logic [2:0] index, input logic [15:0] value);
        case (index)
            CFG_FIRST_CHAR:   font_first      = value[7:0];
            CFG_GLYPH_COUNT:  font_count      = value[8:0];
            CFG_MAX_WIDTH:    font_max_width  = value[4:0];
            CFG_GLYPH_HEIGHT: font_height     = value[4:0];
            CFG_USE_WIDTH:    font_use_width  = value[0];
            CFG_USE_OFFSET:   font_use_offset = value[0];
            default: ;
        endcase
    endfunction

    // ---------------------------------------------------------------- stimulus

    function automatic render_req_t random_req();
        render_req_t r;
        r.op         = OP_DRAW;
        r.load_index = 12'($urandom);
        r.load_value = 16'($urandom);
        r.char_code  = 8'($urandom);
        r.glyph_row  = 4'($urandom);
        r.origin_x   = 11'($urandom);
        r.origin_y   = 11'($urandom);
        r.ink_color  = 16'($urandom);
        r.scale      = 5'($urandom_range(0, 16));
        return r;
    endfunction

    function automatic logic [15:0] random_glyph_word();
        case ($urandom_range(0, 7))
            0:       return GLYPH_ALL_ONES;
            1:       return 16'h0000;
            2:       return GLYPH_MSB >> $urandom_range(0, 15);
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_item(input render_req_t r);
        int gap;
        s_valid        <= 1'b1;
        s_operation    <= r.op;
        s_load_index   <= r.load_index;
        s_load_value   <= r.load_value;
        s_char_code    <= r.char_code;
        s_glyph_row    <= r.glyph_row;
        s_origin_x     <= r.origin_x;
        s_origin_y     <= r.origin_y;
        s_ink_color    <= r.ink_color;
        s_scale_factor <= r.scale;
        do @(posedge aclk); while (!s_ready);
        apply_font_item(r);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(0, 7);
            gap = $urandom_range(0, 4);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
    endtask

    task automatic load_entry(input op_t op, input int index, input logic [15:0] value);
        render_req_t r;
        r            = random_req();
        r.op         = op;
        r.load_index = index[11:0];
        r.load_value = value;
        send_item(r);
    endtask

    // loads any store entry the draw would read that has never been written
    task automatic draw_row(input logic [7:0] ch, input logic [3:0] row,
                            input logic signed [10:0] ox, input logic signed [10:0] oy,
                            input logic [15:0] color, input logic [4:0] scale);
        render_req_t r;
        int          idx;
        int          addr;
        if (glyph_in_font(ch, row, scale, idx)) begin
            if (font_use_width && !width_loaded[idx])
                load_entry(OP_LOAD_WIDTH, idx, 16'($urandom));
            if (font_use_offset && !offset_loaded[idx])
                load_entry(OP_LOAD_OFFSET, idx, 16'($urandom));
            addr = glyph_addr(idx, row);
            if (!glyph_loaded[addr])
                load_entry(OP_LOAD_GLYPH, addr, random_glyph_word());
        end
        r           = random_req();
        r.char_code = ch;
        r.glyph_row = row;
        r.origin_x  = ox;
        r.origin_y  = oy;
        r.ink_color = color;
        r.scale     = scale;
        send_item(r);
    endtask

    // a draw with no set dots gives no beat, so allow for the scan still running
    task automatic wait_for_idle();
        s_valid <= 1'b0;
        while (expected_blocks.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [2:0] index, input logic [15:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_wdata <= value;
        do @(posedge aclk); while (!cfg_ready);
        apply_config(index, value);
    endtask

    task automatic set_font(input logic [7:0] first, input logic [8:0] count,
                            input logic [4:0] maxw, input logic [4:0] height,
                            input bit use_w, input bit use_o);
        wait_for_idle();
        write_reg(CFG_FIRST_CHAR, 16'(first));
        write_reg(CFG_GLYPH_COUNT, 16'(count));
        write_reg(CFG_MAX_WIDTH, 16'(maxw));
        write_reg(CFG_GLYPH_HEIGHT, 16'(height));
        write_reg(CFG_USE_WIDTH, 16'(use_w));
        write_reg(CFG_USE_OFFSET, 16'(use_o));
        cfg_valid <= 1'b0;
    endtask

    // ---------------------------------------------------------------- tests

    task automatic test_default_font();
        load_entry(OP_LOAD_GLYPH, 15, GLYPH_ALL_ONES);
        load_entry(OP_LOAD_GLYPH, 1, 16'h0000);
        load_entry(OP_LOAD_GLYPH, 95 * 16, GLYPH_MSB | 16'h0001);
        // corner origins at full and unit scale; bit 0 lies beyond the default width
        draw_row(8'd32, 4'd15, 11'sh400, 11'sh3FF, 16'hF800, 5'd16);
        draw_row(8'd127, 4'd0, 11'sh3FF, 11'sh400, 16'h07E0, 5'd1);
        draw_row(8'd32, 4'd1, 11'sh000, 11'sh000, 16'h001F, 5'd3);
        draw_row(8'd31, 4'd15, 11'sh010, 11'sh010, 16'hFFFF, 5'd2);
        draw_row(8'd128, 4'd15, 11'sh010, 11'sh010, 16'hFFFF, 5'd2);
        draw_row(8'd32, 4'd15, 11'sh010, 11'sh010, 16'hFFFF, 5'd0);
    endtask

    task automatic test_char_tables();
        set_font(8'd0, 9'd256, 5'd16, 5'd16, 1'b1, 1'b1);
        load_entry(OP_LOAD_GLYPH, 4095, 16'h5A5A);
        load_entry(OP_LOAD_WIDTH, 255, 16'hFFFF);
        load_entry(OP_LOAD_OFFSET, 255, 16'hFFFF);
        draw_row(8'd255, 4'd0, 11'sh123, 11'sh765, 16'hA5A5, 5'd7);
        // start word 4095 plus row 1 wraps to word 0
        draw_row(8'd255, 4'd1, 11'sh000, 11'sh000, 16'h5A5A, 5'd16);
        load_entry(OP_LOAD_WIDTH, 511, 16'h0000);
        load_entry(OP_LOAD_OFFSET, 4095, 16'h0000);
        draw_row(8'd255, 4'd0, 11'sh400, 11'sh400, 16'h0F0F, 5'd16);
        load_entry(OP_LOAD_WIDTH, 0, 16'hFFE0);
        draw_row(8'd0, 4'd3, 11'sh000, 11'sh000, 16'hFFFF, 5'd1);
    endtask

    task automatic test_small_fonts();
        set_font(8'd32, 9'd0, 5'd8, 5'd16, 1'b0, 1'b0);
        draw_row(8'd32, 4'd0, 11'sh000, 11'sh000, 16'hFFFF, 5'd1);
        set_font(8'd255, 9'd1, 5'd1, 5'd1, 1'b0, 1'b0);
        load_entry(OP_LOAD_GLYPH, 0, GLYPH_ALL_ONES);
        draw_row(8'd255, 4'd0, 11'sh3FF, 11'sh3FF, 16'h8410, 5'd16);
        draw_row(8'd255, 4'd1, 11'sh000, 11'sh000, 16'hFFFF, 5'd1);
        draw_row(8'd254, 4'd0, 11'sh000, 11'sh000, 16'hFFFF, 5'd1);
    endtask

    task automatic test_random_fonts();
        int          pick;
        int          span;
        logic [7:0]  ch;
        logic [3:0]  row;
        logic [4:0]  scale;
        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0:       set_font(8'd0, 9'd256, 5'd16, 5'd16, 1'b0, 1'b0);
                1:       set_font(8'd255, 9'd256, 5'd16, 5'd1, 1'b1, 1'b0);
                default: set_font(8'($urandom), 9'($urandom_range(1, 256)),
                                  5'($urandom_range(1, 16)), 5'($urandom_range(1, 16)),
                                  1'($urandom), 1'($urandom));
            endcase
            for (int n = 0; n < 25; n++) begin
                pick = $urandom_range(0, 99);
                span = 256 - int'(font_first);
                if (int'(font_count) < span)
                    span = int'(font_count);
                ch    = 8'($urandom);
                row   = 4'($urandom);
                scale = 5'($urandom_range(0, 16));
                if (pick < 60 && span > 0) begin
                    ch    = font_first + 8'($urandom_range(0, span - 1));
                    row   = 4'($urandom_range(0, int'(font_height) - 1));
                    scale = 5'($urandom_range(1, 16));
                    draw_row(ch, row, 11'($urandom), 11'($urandom), 16'($urandom), scale);
                end else if (pick < 75) begin
                    load_entry(OP_LOAD_GLYPH, $urandom_range(0, GLYPH_WORDS - 1),
                               random_glyph_word());
                end else if (pick < 85) begin
                    load_entry($urandom_range(0, 1) ? OP_LOAD_WIDTH : OP_LOAD_OFFSET,
                               ($urandom_range(0, 3) == 0) ? $urandom_range(CHAR_DEPTH, 4095)
                                                           : $urandom_range(0, CHAR_DEPTH - 1),
                               16'($urandom));
                end else begin
                    draw_row(ch, row, 11'($urandom), 11'($urandom), 16'($urandom), scale);
                end
            end
        end
    endtask

    // ---------------------------------------------------------------- checking

    task automatic report_mismatch(input string what);
        $display("%0t ns: block mismatch: %s", $time, what);
        error_count++;
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_blocks.size() == 0) begin
                report_mismatch($sformatf("unexpected beat x=%0d y=%0d",
                                          m_block_x, m_block_y));
            end else begin
                want_block = expected_blocks.pop_front();
                if (m_block_x !== want_block.x)
                    report_mismatch($sformatf("block_x got %0d want %0d",
                                              m_block_x, want_block.x));
                if (m_block_y !== want_block.y)
                    report_mismatch($sformatf("block_y got %0d want %0d",
                                              m_block_y, want_block.y));
                if (m_block_size !== want_block.size)
                    report_mismatch($sformatf("block_size got %0d want %0d",
                                              m_block_size, want_block.size));
                if (m_block_color !== want_block.color)
                    report_mismatch($sformatf("block_color got %h want %h",
                                              m_block_color, want_block.color));
                if (m_last_block !== want_block.last)
                    report_mismatch($sformatf("last_block got %b want %b",
                                              m_last_block, want_block.last));
            end
        end
    end

    // receiver stalls; the ready style is redrawn at random during the run
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count % 256 == 0)
            ready_style = ready_style_t'($urandom_range(0, 3));
        case (ready_style)
            READY_ALWAYS:   m_ready <= 1'b1;
            READY_MOSTLY:   m_ready <= ($urandom_range(0, 3) != 0);
            READY_SELDOM:   m_ready <= ($urandom_range(0, 3) == 0);
            default:        m_ready <= ((cycle_count % 9) < 5);
        endcase
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("Verification failed");
            $finish;
        end
    end

    initial begin
        font_first      = FIRST_CHAR_RST;
        font_count      = GLYPH_COUNT_RST;
        font_max_width  = MAX_WIDTH_RST;
        font_height     = GLYPH_HEIGHT_RST;
        font_use_width  = 1'b0;
        font_use_offset = 1'b0;

        aresetn        <= 1'b0;
        cfg_valid      <= 1'b0;
        cfg_index      <= CFG_FIRST_CHAR;
        cfg_wdata      <= 16'h0000;
        s_valid        <= 1'b0;
        s_operation    <= OP_LOAD_GLYPH;
        s_load_index   <= 12'h000;
        s_load_value   <= 16'h0000;
        s_char_code    <= 8'h00;
        s_glyph_row    <= 4'h0;
        s_origin_x     <= 11'sh000;
        s_origin_y     <= 11'sh000;
        s_ink_color    <= 16'h0000;
        s_scale_factor <= 5'd0;
        m_ready        <= 1'b0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_default_font();
        test_char_tables();
        test_small_fonts();
        test_random_fonts();

        wait_for_idle();
        if (error_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

>>> scaled_bitmap_glyph_row_renderer.f
design/sbgr_pkg.sv
design/scaled_bitmap_glyph_row_renderer.sv
tb/sv/scaled_bitmap_glyph_row_renderer_tb.sv
